>>> rtl/core/wfsa_pkg.sv
// Shared types, constants and helper functions of the weighted fair share allocator.
package wfsa_pkg;

   // Default sizes.
   localparam int MAX_USERS_DEF  = 64;
   localparam int NUM_SLICES_DEF = 4;

   // Arithmetic widths.
   localparam int TOT_W  = 40;
   localparam int DIV_NW = 48;
   localparam int DIV_DW = 40;

   // Fixed-point constants.
   localparam logic [10:0] QUAL_MIN      = 11'd51;
   localparam logic [10:0] QUAL_MAX      = 11'd1024;
   localparam logic [11:0] PRIO_ONE      = 12'd256;
   localparam logic [15:0] LAT_DEFAULT   = 16'd768;
   localparam logic [15:0] LAT_MOBILITY  = 16'd288;
   localparam logic [23:0] DEMAND_FLOOR  = 24'd256;
   localparam logic [16:0] SHARE_MAX     = 17'd65536;
   // Reciprocal of ten, scaled by 2^22, rounded up; exact for inputs below 2^19.
   localparam logic [18:0] RECIP_TEN     = 19'd419431;

   // Configuration register indexes.
   localparam logic [2:0] CSR_BANDWIDTH = 3'd0;
   localparam logic [2:0] CSR_CELL_TECH = 3'd1;
   localparam logic [2:0] CSR_SLICE0    = 3'd2;
   localparam logic [2:0] CSR_SLICE1    = 3'd3;
   localparam logic [2:0] CSR_SLICE2    = 3'd4;
   localparam logic [2:0] CSR_SLICE3    = 3'd5;

   // One stored user.
   typedef struct packed {
      logic [15:0] user_id;
      logic [1:0]  slice_index;
      logic        slice_known;
      logic [1:0]  user_tech;
      logic [10:0] quality;
      logic [23:0] demand;
      logic        mobile;
   } user_rec_type;

   // Spectral efficiency coefficient per radio tech, Q3.8.
   function automatic logic [10:0] tech_coef(input logic [1:0] tech);
      logic [10:0] c;
      case (tech)
         2'd0: c = 11'd614;
         2'd1: c = 11'd1331;
         2'd2: c = 11'd1818;
         2'd3: c = 11'd1229;
         default: c = 11'd614;
      endcase
      return c;
   endfunction

   // Efficiency at a clamped channel quality, Q3.8.
   function automatic logic [10:0] efficiency(input logic [1:0] tech, input logic [10:0] q);
      logic [10:0] qc;
      logic [22:0] p;
      qc = q;
      if (qc < QUAL_MIN) qc = QUAL_MIN;
      if (qc > QUAL_MAX) qc = QUAL_MAX;
      p = 23'(tech_coef(tech)) * 23'(qc) + 23'd512;
      return p[20:10];
   endfunction

   // Efficiency of the cell tech at quality 0.82, precomputed.
   function automatic logic [10:0] cell_eff(input logic [1:0] tech);
      logic [10:0] e;
      case (tech)
         2'd0: e = 11'd504;
         2'd1: e = 11'd1092;
         2'd2: e = 11'd1491;
         2'd3: e = 11'd1008;
         default: e = 11'd504;
      endcase
      return e;
   endfunction

endpackage

>>> rtl/core/wfsa_store.sv
// User record memory with one write port and a registered read port.
module wfsa_store
   import wfsa_pkg::*;
#(
   parameter int DEPTH = MAX_USERS_DEF,
   parameter int AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  user_rec_type  wr_data,
   input  logic [AW-1:0] rd_addr,
   output user_rec_type  rd_data
);

   user_rec_type mem [DEPTH];
   user_rec_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/wfsa_div.sv
// Restoring serial divider, one quotient bit per cycle.
module wfsa_div
   import wfsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  logic [DIV_NW-1:0] num,
   input  logic [DIV_DW-1:0] den,
   output logic              done,
   output logic [DIV_NW-1:0] quo
);

   localparam int CNT_W = $clog2(DIV_NW + 1);

   logic [DIV_NW-1:0] sh_ff, sh_in;
   logic [DIV_DW-1:0] rem_ff, rem_in;
   logic [DIV_DW-1:0] den_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIV_DW:0]   trial;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial   = {rem_ff, sh_ff[DIV_NW-1]};
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (go) begin
         sh_in  = num;
         rem_in = '0;
         cnt_in = CNT_W'(DIV_NW);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DIV_DW'(trial - {1'b0, den_ff});
            sh_in  = {sh_ff[DIV_NW-2:0], 1'b1};
         end else begin
            rem_in = trial[DIV_DW-1:0];
            sh_in  = {sh_ff[DIV_NW-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      if (go) den_ff <= den;
   end

   assign done = done_ff;
   assign quo  = sh_ff;

endmodule

>>> rtl/core/weighted_fair_share_allocator.sv
// Top level of the weighted fair share allocator: loader, sequencer and result register.
//
// Each request loads in order through accept, efficiency, and weight sum with store write.
// The request marked last_user starts emission, during which busy stays high. Emission
// has a setup step for capacity and then, per stored user, record read and multiplies,
// up to three divisions of 48 bits each on the one serial divider (a start, bit-serial
// steps, and collecting the quotient), and a result step. A division is skipped when
// total weight is zero, when the grant meets demand, or when capacity is zero. Each
// result is shown for one cycle on rsp_valid and cannot be held off by the receiver.
// Configuration writes are meant for times when busy is low.
module weighted_fair_share_allocator
   import wfsa_pkg::*;
#(
   parameter int MAX_USERS  = MAX_USERS_DEF,
   parameter int NUM_SLICES = NUM_SLICES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [15:0] req_user_id,
   input  logic [1:0]  req_slice_index,
   input  logic        req_slice_known,
   input  logic [1:0]  req_user_tech,
   input  logic [10:0] req_channel_quality,
   input  logic [23:0] req_demand_mbps,
   input  logic        req_mobility_event,
   input  logic        req_last_user,
   output logic        rsp_valid,
   output logic [15:0] rsp_out_user_id,
   output logic [1:0]  rsp_out_slice_index,
   output logic [23:0] rsp_grant_mbps,
   output logic [15:0] rsp_latency_ms,
   output logic [16:0] rsp_capacity_share,
   output logic        rsp_users_dropped,
   output logic        rsp_last_result,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [22:0] csr_wdata
);

   localparam int AW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
   localparam int CW = $clog2(MAX_USERS + 1);

   typedef enum logic [14:0] {
      ST_IDLE   = 15'b000000000000001,
      ST_LEFF   = 15'b000000000000010,
      ST_LWGT   = 15'b000000000000100,
      ST_CAP    = 15'b000000000001000,
      ST_RD     = 15'b000000000010000,
      ST_EEFF   = 15'b000000000100000,
      ST_EWGT   = 15'b000000001000000,
      ST_EMUL   = 15'b000000010000000,
      ST_DFAIR  = 15'b000000100000000,
      ST_WFAIR  = 15'b000001000000000,
      ST_DCONG  = 15'b000010000000000,
      ST_WCONG  = 15'b000100000000000,
      ST_DSHARE = 15'b001000000000000,
      ST_WSHARE = 15'b010000000000000,
      ST_OUT    = 15'b100000000000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [11:0] bw_ff;
   logic [1:0]  cell_ff;
   logic [22:0] slice_ff [4];

   always_ff @(posedge clock) begin
      if (reset) begin
         bw_ff       <= 12'd100;
         cell_ff     <= 2'd1;
         slice_ff[0] <= '0;
         slice_ff[1] <= '0;
         slice_ff[2] <= '0;
         slice_ff[3] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_BANDWIDTH: bw_ff       <= csr_wdata[11:0];
            CSR_CELL_TECH: cell_ff     <= csr_wdata[1:0];
            CSR_SLICE0:    slice_ff[0] <= csr_wdata;
            CSR_SLICE1:    slice_ff[1] <= csr_wdata;
            CSR_SLICE2:    slice_ff[2] <= csr_wdata;
            CSR_SLICE3:    slice_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Slice lookup: priority, latency bound and whether the slice is known.
   function automatic logic [22:0] lookup(input user_rec_type u, input logic [22:0] w);
      logic found;
      found = u.slice_known && ({1'b0, u.slice_index} < 3'(NUM_SLICES)) && w[22];
      return found ? w : {1'b0, PRIO_ONE, 10'd0};
   endfunction

   // Control state.
   logic          accept;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [TOT_W-1:0] total_ff, total_in;
   logic          ovf_ff, ovf_in;
   logic          last_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   user_rec_type  u_ff;
   logic [10:0]   eff_ff;
   logic [11:0]   prio_ff;
   logic [9:0]    maxlat_ff;
   logic          found_ff;
   logic [22:0]   cap_ff;
   logic [22:0]   w_ff;
   logic [45:0]   prod_ff;
   logic [15:0]   floor_ff;
   logic [23:0]   grant_ff;
   logic [11:0]   cong_ff;
   logic [16:0]   share_ff;

   // Result register.
   logic [15:0]   out_id_ff;
   logic [1:0]    out_slice_ff;
   logic [23:0]   out_grant_ff;
   logic [15:0]   out_lat_ff;
   logic [16:0]   out_share_ff;
   logic          out_drop_ff;
   logic          out_last_ff;

   // Store and divider connections.
   user_rec_type  rd_rec;
   logic          st_we;
   logic          div_go;
   logic [DIV_NW-1:0] div_num;
   logic [DIV_DW-1:0] div_den;
   logic          div_done;
   logic [DIV_NW-1:0] div_quo;

   assign accept = start && (state_ff == ST_IDLE);
   assign st_we  = (state_ff == ST_LWGT) && (count_ff != CW'(MAX_USERS));

   wfsa_store #(
      .DEPTH (MAX_USERS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (u_ff),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_rec)
   );

   wfsa_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Lookup results for the loading request and for the record being emitted, and the emission arithmetic.
   logic [22:0] l_word, e_word;
   logic [22:0] weight;
   logic [18:0] flr_b;
   logic [37:0] flr_p;
   logic [23:0] dem_floor;
   logic [23:0] diff;
   logic [35:0] cong_num;
   logic [16:0] lat_sum;

   always_comb begin
      l_word    = lookup(u_ff, slice_ff[u_ff.slice_index]);
      e_word    = lookup(rd_rec, slice_ff[rd_rec.slice_index]);
      weight    = 23'(prio_ff) * 23'(eff_ff);
      flr_b     = 19'({maxlat_ff, 8'd0}) + 19'({maxlat_ff, 5'd0}) + 19'd5;
      flr_p     = flr_b * RECIP_TEN;
      dem_floor = (rd_rec.demand > DEMAND_FLOOR) ? rd_rec.demand : DEMAND_FLOOR;
      diff      = rd_rec.demand - grant_ff;
      cong_num  = 36'({diff, 10'd0}) + 36'({diff, 9'd0}) + 36'({diff, 6'd0})
                + 36'(dem_floor[23:1]);
      lat_sum   = 17'(floor_ff) + 17'(cong_ff)
                + (rd_rec.mobile ? 17'(LAT_MOBILITY) : 17'd0);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = 1'b0;
      div_go       = 1'b0;
      div_num      = '0;
      div_den      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LEFF;
         end
         ST_LEFF: state_in = ST_LWGT;
         ST_LWGT: begin
            if (count_ff != CW'(MAX_USERS)) begin
               count_in = count_ff + 1'b1;
               total_in = total_ff + TOT_W'(weight);
            end else begin
               ovf_in = 1'b1;
            end
            state_in = last_ff ? ST_CAP : ST_IDLE;
         end
         ST_CAP: state_in = (count_ff == '0) ? ST_IDLE : ST_RD;
         ST_RD:   state_in = ST_EEFF;
         ST_EEFF: state_in = ST_EWGT;
         ST_EWGT: state_in = ST_EMUL;
         ST_EMUL: state_in = ST_DFAIR;
         ST_DFAIR: begin
            if (total_ff == '0) begin
               state_in = ST_DCONG;
            end else begin
               div_go   = 1'b1;
               div_num  = DIV_NW'(prod_ff);
               div_den  = total_ff;
               state_in = ST_WFAIR;
            end
         end
         ST_WFAIR: if (div_done) state_in = ST_DCONG;
         ST_DCONG: begin
            if (grant_ff < rd_rec.demand) begin
               div_go   = 1'b1;
               div_num  = DIV_NW'(cong_num);
               div_den  = DIV_DW'(dem_floor);
               state_in = ST_WCONG;
            end else begin
               state_in = ST_DSHARE;
            end
         end
         ST_WCONG: if (div_done) state_in = ST_DSHARE;
         ST_DSHARE: begin
            if (cap_ff == '0) begin
               state_in = ST_OUT;
            end else begin
               div_go   = 1'b1;
               div_num  = DIV_NW'({grant_ff, 16'd0});
               div_den  = DIV_DW'(cap_ff);
               state_in = ST_WSHARE;
            end
         end
         ST_WSHARE: if (div_done) state_in = ST_OUT;
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            if (idx_ff + 1'b1 == count_ff) begin
               idx_in   = '0;
               count_in = '0;
               total_in = '0;
               ovf_in   = 1'b0;
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers, loaded per state.
   always_ff @(posedge clock) begin
      if (accept) begin
         u_ff.user_id     <= req_user_id;
         u_ff.slice_index <= req_slice_index;
         u_ff.slice_known <= req_slice_known;
         u_ff.user_tech   <= req_user_tech;
         u_ff.quality     <= req_channel_quality;
         u_ff.demand      <= req_demand_mbps;
         u_ff.mobile      <= req_mobility_event;
         last_ff          <= req_last_user;
      end
      case (state_ff)
         ST_LEFF: begin
            eff_ff  <= efficiency(u_ff.user_tech, u_ff.quality);
            prio_ff <= l_word[21:10];
         end
         ST_CAP: cap_ff <= 23'(bw_ff) * 23'(cell_eff(cell_ff));
         ST_EEFF: begin
            eff_ff    <= efficiency(rd_rec.user_tech, rd_rec.quality);
            prio_ff   <= e_word[21:10];
            maxlat_ff <= e_word[9:0];
            found_ff  <= e_word[22];
         end
         ST_EWGT: begin
            w_ff     <= weight;
            floor_ff <= found_ff ? flr_p[37:22] : LAT_DEFAULT;
         end
         ST_EMUL: prod_ff <= cap_ff * w_ff;
         ST_DFAIR: if (total_ff == '0) grant_ff <= '0;
         ST_WFAIR: begin
            if (div_done) begin
               grant_ff <= (div_quo < DIV_NW'(rd_rec.demand)) ? div_quo[23:0]
                                                              : rd_rec.demand;
            end
         end
         ST_DCONG: if (!(grant_ff < rd_rec.demand)) cong_ff <= '0;
         ST_WCONG: if (div_done) cong_ff <= div_quo[11:0];
         ST_DSHARE: if (cap_ff == '0) share_ff <= '0;
         ST_WSHARE: begin
            if (div_done) begin
               share_ff <= (div_quo > DIV_NW'(SHARE_MAX)) ? SHARE_MAX : div_quo[16:0];
            end
         end
         ST_OUT: begin
            out_id_ff    <= rd_rec.user_id;
            out_slice_ff <= rd_rec.slice_index;
            out_grant_ff <= grant_ff;
            out_lat_ff   <= lat_sum[16] ? 16'hFFFF : lat_sum[15:0];
            out_share_ff <= share_ff;
            out_drop_ff  <= ovf_ff;
            out_last_ff  <= (idx_ff + 1'b1 == count_ff);
         end
         default: ;
      endcase
   end

   // Outputs.
   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_user_id     = out_id_ff;
   assign rsp_out_slice_index = out_slice_ff;
   assign rsp_grant_mbps      = out_grant_ff;
   assign rsp_latency_ms      = out_lat_ff;
   assign rsp_capacity_share  = out_share_ff;
   assign rsp_users_dropped   = out_drop_ff;
   assign rsp_last_result     = rsp_valid_ff & out_last_ff;

   // The fill count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_USERS))
      else $error("user count beyond store depth");

   // The final result of a batch leaves the block idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |-> !busy)
      else $error("block still busy after final result");

   // An accepted request always makes the block busy next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not start work");

   // The divider is only started while emitting.
   a_div_emit: assert property (@(posedge clock) disable iff (reset)
      div_go |-> busy && (count_ff != '0))
      else $error("division started outside emission");

endmodule
